/* rtl/core/scd_pkg.sv */
package scd_pkg;

  // Frame buffer depth; lengths beyond it are cut to it.
  localparam int FRAME_DEPTH = 32;
  localparam int LEN_W       = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int WORD_W      = 32;

  localparam logic [LEN_W-1:0] DEPTH_LEN      = LEN_W'(FRAME_DEPTH);
  localparam logic [LEN_W-1:0] DEFAULT_LEN    = LEN_W'(15);
  localparam logic [LEN_W-1:0] MOTION_MIN_LEN = LEN_W'(15);
  localparam logic [LEN_W-1:0] PLAIN_MIN_LEN  = LEN_W'(3);
  localparam logic [7:0]       START_BYTE     = 8'h40;

  // Frame positions of the command byte and the motion words (little endian).
  localparam int CMD_POS     = 1;
  localparam int SPEED_POS   = 2;
  localparam int HEADING_POS = 6;
  localparam int TURN_POS    = 10;
  localparam int STORE_LAST  = TURN_POS + 3;

  localparam int OUT_DATA_W = 8 + 3 * WORD_W + 8 + 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MOTION_CODE = 8'd0,
    REG_PLAIN_CODE  = 8'd1,
    REG_MOTION_LEN  = 8'd2,
    REG_PLAIN_LEN   = 8'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    STAT_MOTION_OK = 2'd0,
    STAT_PLAIN_OK  = 2'd1,
    STAT_OTHER_OK  = 2'd2,
    STAT_BAD_SUM   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]       motion_code;
    logic [7:0]       plain_code;
    logic [LEN_W-1:0] motion_len;
    logic [LEN_W-1:0] plain_len;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [7:0]        cmd;
    logic [WORD_W-1:0] speed;
    logic [WORD_W-1:0] heading;
    logic [WORD_W-1:0] turn_rate;
    logic [7:0]        calc_sum;
    logic [7:0]        rx_sum;
  } result_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                 input logic [LEN_W-1:0] lo);
    logic [LEN_W-1:0] v;
    v = len;
    if (v < lo) v = lo;
    if (v > DEPTH_LEN) v = DEPTH_LEN;
    return v;
  endfunction

endpackage

/* rtl/core/scd_cfg_regs.sv */
module scd_cfg_regs
  import scd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [31:0]          wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_code <= 8'd97;
      cfg_r.plain_code  <= 8'd122;
      cfg_r.motion_len  <= LEN_W'(15);
      cfg_r.plain_len   <= LEN_W'(15);
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_MOTION_CODE: cfg_r.motion_code <= wr_data[7:0];
        REG_PLAIN_CODE:  cfg_r.plain_code  <= wr_data[7:0];
        REG_MOTION_LEN:  cfg_r.motion_len  <= wr_data[LEN_W-1:0];
        REG_PLAIN_LEN:   cfg_r.plain_len   <= wr_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

/* rtl/core/scd_in_reg.sv */
module scd_in_reg
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       s_valid,
  output logic       s_ready,
  input  logic [7:0] s_data,
  output logic       vld,
  output logic [7:0] data,
  input  logic       take
);

  logic       vld_r;
  logic [7:0] data_r;

  assign s_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (s_ready) begin
      vld_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      data_r <= s_data;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;

endmodule

/* rtl/core/scd_parser.sv */
module scd_parser
  import scd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       go,
  input  logic [7:0] rx,
  output logic       res_vld,
  output result_t    res
);

  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [LEN_W-1:0]  exp_r, exp_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [WORD_W-1:0] speed_r, speed_nxt;
  logic [WORD_W-1:0] heading_r, heading_nxt;
  logic [WORD_W-1:0] turn_r, turn_nxt;
  logic [7:0]        store_r [CMD_POS:STORE_LAST];
  logic [7:0]        store_nxt [CMD_POS:STORE_LAST];
  logic [LEN_W-1:0]  count;
  logic [LEN_W-1:0]  exp_len;

  // Byte positions seen with the current byte already written.
  always_comb begin
    for (int k = CMD_POS; k <= STORE_LAST; k++) begin
      store_nxt[k] = (cnt_r == LEN_W'(k)) ? rx : store_r[k];
    end
  end

  assign count = cnt_r + LEN_W'(1);

  always_comb begin
    if (count == LEN_W'(2)) begin
      if (rx == cfg.motion_code) exp_len = clamp_len(cfg.motion_len, MOTION_MIN_LEN);
      else if (rx == cfg.plain_code) exp_len = clamp_len(cfg.plain_len, PLAIN_MIN_LEN);
      else exp_len = DEFAULT_LEN;
    end else begin
      exp_len = exp_r;
    end
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    exp_nxt     = exp_r;
    sum_nxt     = sum_r;
    speed_nxt   = speed_r;
    heading_nxt = heading_r;
    turn_nxt    = turn_r;
    res_vld     = 1'b0;
    res.status  = STAT_BAD_SUM;
    res.cmd     = store_nxt[CMD_POS];
    res.calc_sum = sum_r;
    res.rx_sum  = rx;
    if (cnt_r == '0) begin
      cnt_nxt = (rx == START_BYTE) ? LEN_W'(1) : '0;
      exp_nxt = DEFAULT_LEN;
      sum_nxt = '0;
    end else if (count < exp_len) begin
      cnt_nxt = count;
      exp_nxt = exp_len;
      sum_nxt = sum_r + rx;
    end else begin
      // checksum byte: close the frame
      res_vld = 1'b1;
      if (sum_r != rx) begin
        res.status = STAT_BAD_SUM;
      end else if (res.cmd == cfg.motion_code) begin
        res.status  = STAT_MOTION_OK;
        speed_nxt   = {store_nxt[SPEED_POS+3], store_nxt[SPEED_POS+2],
                       store_nxt[SPEED_POS+1], store_nxt[SPEED_POS]};
        heading_nxt = {store_nxt[HEADING_POS+3], store_nxt[HEADING_POS+2],
                       store_nxt[HEADING_POS+1], store_nxt[HEADING_POS]};
        turn_nxt    = {store_nxt[TURN_POS+3], store_nxt[TURN_POS+2],
                       store_nxt[TURN_POS+1], store_nxt[TURN_POS]};
      end else if (res.cmd == cfg.plain_code) begin
        res.status = STAT_PLAIN_OK;
      end else begin
        res.status = STAT_OTHER_OK;
      end
      cnt_nxt = '0;
      exp_nxt = DEFAULT_LEN;
      sum_nxt = '0;
    end
    res.speed     = speed_nxt;
    res.heading   = heading_nxt;
    res.turn_rate = turn_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      exp_r     <= DEFAULT_LEN;
      sum_r     <= '0;
      speed_r   <= '0;
      heading_r <= '0;
      turn_r    <= '0;
    end else if (go) begin
      cnt_r     <= cnt_nxt;
      exp_r     <= exp_nxt;
      sum_r     <= sum_nxt;
      speed_r   <= speed_nxt;
      heading_r <= heading_nxt;
      turn_r    <= turn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int k = CMD_POS; k <= STORE_LAST; k++) begin
        store_r[k] <= store_nxt[k];
      end
    end
  end

endmodule

/* rtl/core/scd_out_reg.sv */
module scd_out_reg
  import scd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    space,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_res
);

  logic    vld_r;
  result_t res_r;

  assign space = !vld_r || m_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (space) begin
      vld_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (space && load) begin
      res_r <= res;
    end
  end

  assign m_valid = vld_r;
  assign m_res   = res_r;

endmodule

/* rtl/core/serial_command_deframer.sv */
// Serial command deframer.
// in_*  : one received byte per transfer (in_tdata[7:0] = rx_byte).
// out_* : one transfer per finished frame; out_tuser carries the frame status
//         (motion ok, plain ok, unknown command ok, checksum mismatch), out_tdata
//         the command byte, the three held motion words, and both checksums.
// cfg_* : register writes (index 0 motion code, 1 plain code, 2 motion frame
//         length, 3 plain frame length); always ready, write only when idle.
// Frames open with '@'; other leading bytes are dropped silently. The command
// byte fixes the frame length; the last byte is the checksum of the bytes
// between start and checksum.
// Throughput: one byte per cycle while the result register is free or being read;
// the parse step sits between the input register and the result register.
// A checksum byte passes the input register and the combinational parse step;
// its result is then registered in the output register that drives out_tvalid.
// Reset clears the frame counter, running sum, held words and both pipeline
// valids; registers return to 'a', 'z', 15, 15.
// When the receiver stalls, the result stays put, the parse stage stops, and
// in_tready drops once the input register is also full; nothing is lost.
module serial_command_deframer
  import scd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] rx_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] command_byte, [39:8] speed_bits,
                                            // [71:40] heading_bits,
                                            // [103:72] turn_rate_bits,
                                            // [111:104] computed_sum,
                                            // [119:112] received_sum
  output logic [1:0]            out_tuser,  // [1:0] frame_status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]           cfg_data
);

  cfg_t       cfg;
  logic       byte_vld;
  logic [7:0] byte_q;
  logic       space;
  logic       go;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  assign cfg_ready = 1'b1;

  scd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // Parse step runs whenever a byte is held and the result slot can take one.
  assign go = byte_vld && space;

  scd_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (in_tdata),
    .vld     (byte_vld),
    .data    (byte_q),
    .take    (go)
  );

  scd_parser u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .go      (go),
    .rx      (byte_q),
    .res_vld (res_vld),
    .res     (res)
  );

  scd_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (go && res_vld),
    .res     (res),
    .space   (space),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_res   (out_res)
  );

  assign out_tuser = out_res.status;
  assign out_tdata = {out_res.rx_sum, out_res.calc_sum, out_res.turn_rate,
                      out_res.heading, out_res.speed, out_res.cmd};

endmodule

/* rtl/core/scd_checker.sv */
module scd_checker
  import scd_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // No result right out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A fresh result must trace back to a byte transfer through the input register.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a byte transfer");

  // A result with a good status must carry equal sums.
  a_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_BAD_SUM) |-> out_tdata[111:104] == out_tdata[119:112])
    else $error("good status with unequal sums");

endmodule

bind serial_command_deframer scd_checker u_scd_checker (.*);
